FILE: src/lfu_cache_lru_tiebreak_macros.svh
// assertion macros for the lfu cache block
// no dependencies
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
// implication checked on every clock edge outside reset
`define LFU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/lfu_pkg.sv
// shared types and constants of the lfu cache
// no dependencies
`default_nettype none
package lfu_pkg;
  localparam int unsigned Entries   = 16;
  localparam int unsigned CountBits = 16;
  localparam int unsigned IdxBits   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned OccBits   = $clog2(Entries + 1);
  localparam int unsigned CapBits   = 5;
  localparam logic [CapBits-1:0] CapReset = CapBits'(16);
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic ModeGet = 1'b0;
  localparam logic ModePut = 1'b1;

  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CountBits-1:0] count_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] lookup_key;
    logic [31:0] put_value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
    logic        dropped;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic search;
    logic update;
  } cmd_t;
endpackage
`default_nettype wire

FILE: src/lfu_ctrl.sv
// controller state machine of the lfu cache
// depends on lfu_pkg
`default_nettype none
`include "lfu_cache_lru_tiebreak_macros.svh"
module lfu_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output lfu_pkg::cmd_t    cmd_o
);
  import lfu_pkg::*;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StSearch = 3'b010,
    StUpdate = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // a new item may enter when idle and the output slot is or gets free
  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load_req = 1'b1;
          state_d        = StSearch;
        end
      end
      StSearch: begin
        cmd_o.search = 1'b1;
        state_d      = StUpdate;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `LFU_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `LFU_ASSERT_NEXT(a_acc_search, clk_i, rst_ni, accept, state_q == StSearch)
  `LFU_ASSERT_NEXT(a_upd_valid, clk_i, rst_ni, state_q == StUpdate, out_valid_q)
  `LFU_ASSERT_IMP(a_no_overrun, clk_i, rst_ni, state_q == StUpdate, !out_valid_q || out_ready_i)
endmodule
`default_nettype wire

FILE: src/lfu_dp.sv
// entry table, search and update datapath of the lfu cache
// depends on lfu_pkg
`default_nettype none
module lfu_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  lfu_pkg::cmd_t               cmd_i,
  input  lfu_pkg::req_t               req_i,
  input  wire logic [lfu_pkg::CapBits-1:0] cap_i,
  output lfu_pkg::rsp_t               rsp_o
);
  import lfu_pkg::*;

  logic [Entries-1:0] valid_q;
  logic [31:0]        key_q   [Entries];
  logic [31:0]        value_q [Entries];
  count_t             count_q [Entries];
  idx_t               rec_q   [Entries];

  req_t   req_q;
  rsp_t   rsp_q;
  // search results
  logic   found_q, vic_ok_q, free_ok_q, full_q;
  idx_t   found_idx_q, vic_idx_q, free_idx_q;

  // parallel key match and free entry search
  logic [Entries-1:0] match;
  logic   found_c, free_c;
  idx_t   found_idx_c, free_idx_c;
  logic [OccBits-1:0] occ_c;
  always_comb begin
    found_c = 1'b0; free_c = 1'b0;
    found_idx_c = '0; free_idx_c = '0; occ_c = '0;
    for (int i = 0; i < Entries; i++) begin
      match[i] = valid_q[i] && (key_q[i] == req_q.lookup_key);
      if (valid_q[i]) occ_c = occ_c + OccBits'(1);
      if (match[i] && !found_c) begin
        found_c = 1'b1; found_idx_c = idx_t'(i);
      end
      if (!valid_q[i] && !free_c) begin
        free_c = 1'b1; free_idx_c = idx_t'(i);
      end
    end
  end

  // victim: lowest count, then oldest; recency ranks are distinct among valid
  // entries, so a pairwise tree over the table settles it
  logic   t_ok  [Entries];
  count_t t_cnt [Entries];
  idx_t   t_rec [Entries];
  idx_t   t_idx [Entries];
  logic   vic_ok_c;
  idx_t   vic_idx_c;
  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      t_ok[i]  = valid_q[i];
      t_cnt[i] = count_q[i];
      t_rec[i] = rec_q[i];
      t_idx[i] = idx_t'(i);
    end
    for (int s = 1; s < Entries; s = s * 2) begin
      for (int i = 0; i + s < Entries; i = i + 2 * s) begin
        if (t_ok[i + s] && (!t_ok[i] || t_cnt[i + s] < t_cnt[i] ||
            (t_cnt[i + s] == t_cnt[i] && t_rec[i + s] > t_rec[i]))) begin
          t_ok[i]  = 1'b1;
          t_cnt[i] = t_cnt[i + s];
          t_rec[i] = t_rec[i + s];
          t_idx[i] = t_idx[i + s];
        end
      end
    end
    vic_ok_c  = t_ok[0];
    vic_idx_c = t_idx[0];
  end

  // effective capacity
  logic [CapBits-1:0] cap_eff;
  assign cap_eff = (32'(cap_i) > Entries) ? CapBits'(Entries) : cap_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.search) begin
      found_q <= found_c; found_idx_q <= found_idx_c;
      free_ok_q <= free_c; free_idx_q <= free_idx_c;
      vic_ok_q <= vic_ok_c; vic_idx_q <= vic_idx_c;
      full_q <= (32'(occ_c) >= 32'(cap_eff));
    end
  end

  // read-modify-write of entry state
  idx_t slot;
  logic do_evict, do_insert, do_bump;
  idx_t ref_rec;
  always_comb begin
    do_bump   = found_q;
    do_evict  = !found_q && req_q.mode == ModePut && cap_eff != '0 && full_q && vic_ok_q;
    do_insert = !found_q && req_q.mode == ModePut && cap_eff != '0 &&
                (do_evict || free_ok_q);
    slot      = found_q ? found_idx_q : (do_evict ? vic_idx_q : free_idx_q);
    ref_rec   = rec_q[slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= '0;
    else if (cmd_i.update && do_insert) valid_q[slot] <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rsp_q.hit         <= found_q;
      rsp_q.read_value  <= (found_q && req_q.mode == ModeGet) ? value_q[found_idx_q] : '0;
      rsp_q.evicted     <= do_evict;
      rsp_q.evicted_key <= do_evict ? key_q[vic_idx_q] : '0;
      rsp_q.dropped     <= !found_q && req_q.mode == ModePut && cap_eff == '0;
      for (int i = 0; i < Entries; i++) begin
        if (valid_q[i] && idx_t'(i) != slot) begin
          if ((do_bump && rec_q[i] < ref_rec) ||
              (do_insert && (!do_evict || rec_q[i] < ref_rec)))
            rec_q[i] <= rec_q[i] + idx_t'(1);
        end
      end
      if (do_bump) begin
        rec_q[slot] <= '0;
        if (count_q[slot] != CountMax) count_q[slot] <= count_q[slot] + count_t'(1);
        if (req_q.mode == ModePut) value_q[slot] <= req_q.put_value;
      end
      if (do_insert) begin
        rec_q[slot]   <= '0;
        count_q[slot] <= count_t'(1);
        key_q[slot]   <= req_q.lookup_key;
        value_q[slot] <= req_q.put_value;
      end
    end
  end

  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

FILE: src/lfu_cache_lru_tiebreak.sv
// lfu cache with lru tie-break: after a transaction is accepted it passes a
// search state, then an update state that registers the result; the next
// transaction is accepted no earlier than the cycle the result leaves, so
// a new item is not taken while the last one is in flight. reset clears all
// valid bits at once and sets capacity to 16; no clearing pass.
// top level: depends on lfu_pkg, lfu_ctrl, lfu_dp
`default_nettype none
module lfu_cache_lru_tiebreak (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  lfu_pkg::req_t      in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output lfu_pkg::rsp_t      out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic [4:0]    cfg_wdata_i
);
  import lfu_pkg::*;

  cmd_t cmd;
  logic [CapBits-1:0] cap_q;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CapReset;
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd)
  );

  lfu_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i(in_data_i), .cap_i(cap_q),
    .rsp_o(out_data_o)
  );
endmodule
`default_nettype wire

FILE: verif/tb_lfu_cache_lru_tiebreak.sv
// testbench for the lfu cache with lru tie-break: directed table, then random traffic
// depends on lfu_pkg and lfu_cache_lru_tiebreak; predicts every response in a local cache model
`timescale 1ns / 1ps
module tb_lfu_cache_lru_tiebreak;
  import lfu_pkg::*;

  localparam int unsigned KeepMax = (1 << CountBits) - 1;
  localparam int ExpDepth = 2048;
  localparam int RowDepth = 32;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i = 1'b1;
  rsp_t out_data_o;
  logic cfg_we_i;
  logic [4:0] cfg_wdata_i;

  lfu_cache_lru_tiebreak dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // predictor state of the cache
  logic        slot_used [Entries];
  logic [31:0] slot_key [Entries];
  logic [31:0] slot_val [Entries];
  int unsigned slot_uses [Entries];
  int unsigned slot_age [Entries];
  int unsigned cap_setting;

  // expected responses in order: written by the sender, read by the checker
  rsp_t exp_mem [ExpDepth];
  int   exp_wr = 0;
  int   exp_rd = 0;
  int   fail_cnt = 0;
  int   row_err = 0;
  int   send_idle_pct;
  int   recv_idle_pct;

  // directed table row: request, optional typed expected response
  typedef struct {
    req_t req;
    bit   has_rsp;
    rsp_t rsp;
  } row_t;
  row_t dir_rows [RowDepth];
  int   n_rows;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tb_lfu_cache_lru_tiebreak failed");
    $finish;
  end

  function automatic void cache_clear();
    for (int i = 0; i < Entries; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_val[i] = '0;
      slot_uses[i] = 0;
      slot_age[i] = 0;
    end
    cap_setting = 16;
  endfunction

  function automatic void touch_slot(int s);
    if (slot_uses[s] < KeepMax) slot_uses[s]++;
    for (int i = 0; i < Entries; i++)
      if (slot_used[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // computes the response of one request and updates the cache state
  function automatic rsp_t cache_access(req_t r);
    rsp_t o;
    int hit_slot, free_slot, victim_slot, slot, va;
    int unsigned occ, cap;
    o = '0;
    hit_slot = -1;
    free_slot = -1;
    victim_slot = -1;
    occ = 0;
    cap = (cap_setting > Entries) ? Entries : cap_setting;
    for (int i = 0; i < Entries; i++) begin
      if (slot_used[i]) begin
        occ++;
        if (hit_slot < 0 && slot_key[i] == r.lookup_key) hit_slot = i;
        if (victim_slot < 0 || slot_uses[i] < slot_uses[victim_slot] ||
            (slot_uses[i] == slot_uses[victim_slot] &&
             slot_age[i] > slot_age[victim_slot])) victim_slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit_slot >= 0) begin
      o.hit = 1'b1;
      if (r.mode == ModePut) slot_val[hit_slot] = r.put_value;
      else o.read_value = slot_val[hit_slot];
      touch_slot(hit_slot);
      return o;
    end
    if (r.mode == ModeGet) return o;
    if (cap == 0) begin
      o.dropped = 1'b1;
      return o;
    end
    slot = free_slot;
    if (occ >= cap && victim_slot >= 0) begin
      va = slot_age[victim_slot];
      o.evicted = 1'b1;
      o.evicted_key = slot_key[victim_slot];
      slot_used[victim_slot] = 1'b0;
      for (int i = 0; i < Entries; i++)
        if (slot_used[i] && slot_age[i] > va) slot_age[i]--;
      slot = victim_slot;
    end
    if (slot < 0) return o;
    for (int i = 0; i < Entries; i++)
      if (slot_used[i]) slot_age[i]++;
    slot_used[slot] = 1'b1;
    slot_key[slot] = r.lookup_key;
    slot_val[slot] = r.put_value;
    slot_uses[slot] = 1;
    slot_age[slot] = 0;
    return o;
  endfunction

  // drive one request transaction and record its expected response
  task automatic send_req(req_t r, bit has_rsp, rsp_t typed);
    rsp_t p;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    p = cache_access(r);
    if (has_rsp && p != typed) begin
      $error("table row disagrees with predictor: exp %h got %h", typed, p);
      row_err++;
    end
    exp_mem[exp_wr % ExpDepth] = has_rsp ? typed : p;
    exp_wr++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (exp_rd != exp_wr) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_cap(int unsigned v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[4:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cap_setting = v;
  endtask

  function automatic req_t mk(logic m, logic [31:0] k, logic [31:0] v);
    req_t r;
    r.mode = m;
    r.lookup_key = k;
    r.put_value = v;
    return r;
  endfunction

  function automatic rsp_t rs(logic h, logic [31:0] rv, logic ev, logic [31:0] ek,
                              logic dr);
    rsp_t o;
    o.hit = h;
    o.read_value = rv;
    o.evicted = ev;
    o.evicted_key = ek;
    o.dropped = dr;
    return o;
  endfunction

  function automatic void add_row(req_t r, bit h, rsp_t o);
    dir_rows[n_rows].req = r;
    dir_rows[n_rows].has_rsp = h;
    dir_rows[n_rows].rsp = o;
    n_rows++;
  endfunction

  // response checker
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_rd == exp_wr) begin
        $error("response transaction with nothing expected");
        fail_cnt++;
      end else begin
        e = exp_mem[exp_rd % ExpDepth];
        exp_rd++;
        if (e.hit !== out_data_o.hit) begin
          $error("hit exp %h got %h", e.hit, out_data_o.hit); fail_cnt++;
        end
        if (e.read_value !== out_data_o.read_value) begin
          $error("read_value exp %h got %h", e.read_value, out_data_o.read_value);
          fail_cnt++;
        end
        if (e.evicted !== out_data_o.evicted) begin
          $error("evicted exp %h got %h", e.evicted, out_data_o.evicted); fail_cnt++;
        end
        if (e.evicted_key !== out_data_o.evicted_key) begin
          $error("evicted_key exp %h got %h", e.evicted_key, out_data_o.evicted_key);
          fail_cnt++;
        end
        if (e.dropped !== out_data_o.dropped) begin
          $error("dropped exp %h got %h", e.dropped, out_data_o.dropped); fail_cnt++;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    out_ready_i <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
  end

  // random traffic over a small key pool so hits and evictions are frequent
  task automatic random_run(int n);
    logic [31:0] k, v;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 80) k = $urandom_range(23);
      else if (pick < 90) k = 32'hFFFF_FFF0 | $urandom_range(15);
      else k = $urandom;
      v = $urandom;
      send_req(mk(1'($urandom_range(1)), k, v), 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned caps [6] = '{16, 1, 31, 4, 9, 0};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    n_rows = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cache_clear();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table: empty cache, extremes, hits and eviction
    add_row(mk(ModeGet, 32'h0, 32'h0), 1'b1, rs(1'b0, 0, 1'b0, 0, 1'b0));
    add_row(mk(ModePut, 32'h0, 32'hFFFF_FFFF), 1'b1, rs(1'b0, 0, 1'b0, 0, 1'b0));
    add_row(mk(ModeGet, 32'h0, 32'h1234), 1'b1, rs(1'b1, 32'hFFFF_FFFF, 1'b0, 0, 1'b0));
    add_row(mk(ModePut, 32'hFFFF_FFFF, 32'h0), 1'b1, rs(1'b0, 0, 1'b0, 0, 1'b0));
    add_row(mk(ModeGet, 32'hFFFF_FFFF, 32'h0), 1'b1, rs(1'b1, 0, 1'b0, 0, 1'b0));
    add_row(mk(ModePut, 32'h0, 32'hA5A5_5A5A), 1'b1, rs(1'b1, 0, 1'b0, 0, 1'b0));
    add_row(mk(ModeGet, 32'h0, 32'h0), 1'b0, '0);
    add_row(mk(ModeGet, 32'h5555_AAAA, 32'h0), 1'b1, rs(1'b0, 0, 1'b0, 0, 1'b0));
    for (int i = 0; i < 16; i++) add_row(mk(ModePut, 100 + i, i), 1'b0, '0);
    for (int i = 0; i < n_rows; i++)
      send_req(dir_rows[i].req, dir_rows[i].has_rsp, dir_rows[i].rsp);

    // capacity zero: put of a present key updates, new key is dropped
    write_cap(0);
    send_req(mk(ModePut, 32'h0, 32'h77), 1'b1, rs(1'b1, 0, 1'b0, 0, 1'b0));
    send_req(mk(ModePut, 32'hDEAD_BEEF, 32'h1), 1'b1, rs(1'b0, 0, 1'b0, 0, 1'b1));
    // capacity lowered below occupancy
    write_cap(2);
    send_req(mk(ModePut, 32'h0BAD_F00D, 32'h2), 1'b0, '0);
    send_req(mk(ModePut, 32'h0BAD_F00E, 32'h3), 1'b0, '0);

    // ties settled by recency, then counts grow on one key
    write_cap(3);
    for (int i = 0; i < 3; i++) send_req(mk(ModePut, 200 + i, i), 1'b0, '0);
    for (int i = 0; i < 20; i++) send_req(mk(ModeGet, 200, 0), 1'b0, '0);

    // random phases over several capacities and idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 36 : 0;
      for (int c = 0; c < 6; c++) begin
        write_cap(caps[(c + ph) % 6]);
        random_run(56);
      end
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0 && row_err == 0 && exp_rd == exp_wr) begin
      $display("tb_lfu_cache_lru_tiebreak passed");
    end else begin
      $display("tb_lfu_cache_lru_tiebreak failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+src
src/lfu_pkg.sv
src/lfu_ctrl.sv
src/lfu_dp.sv
src/lfu_cache_lru_tiebreak.sv
verif/tb_lfu_cache_lru_tiebreak.sv
